@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker of the generator.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: label");

// Property checked at every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

@@ rtl/mtg_pkg.sv @@
// Package of the MT19937 generator: sizes, constants, the command and status
// structs between controller and datapath, and the twist/temper/seed functions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int MAX_BURST     = 64;

    localparam int WORD_W  = 32;
    localparam int ADDR_W  = $clog2(STATE_WORDS);
    localparam int COUNT_W = 7;

    localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [COUNT_W-1:0] BURST_MAX = COUNT_W'(MAX_BURST);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic run_load;    // capture the request length, reset the seeding index
        logic seed_step;   // write one entry of the seeding pass
        logic read_issue;  // read the next and middle entries
        logic twist;       // twist one entry and load the output register
    } mtg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_zero;    // the offered request asks for no words
        logic needs_seed;  // the state must be seeded before the next word
        logic seed_last;   // the seeding pass is at its last entry
        logic run_last;    // the word being made is the last of the run
        logic out_free;    // the output register can take a word this cycle
    } mtg_stat_t;

    // Next entry of the seeding recurrence, low 32 bits of the product kept.
    function automatic logic [WORD_W-1:0] seed_next(input logic [WORD_W-1:0] prev,
                                                   input logic [ADDR_W-1:0] idx);
        logic [WORD_W-1:0] mixed;
        logic [2*WORD_W-1:0] prod;
        mixed = prev ^ (prev >> 30);
        prod  = mixed * SEED_MULT;
        return prod[WORD_W-1:0] + WORD_W'(idx);
    endfunction

    // New value of one entry from the current, next and middle entries.
    function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                    input logic [WORD_W-1:0] nxt,
                                                    input logic [WORD_W-1:0] mid);
        logic [WORD_W-1:0] y;
        y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
        return mid ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
    endfunction

    // Output tempering.
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] w;
        w = x ^ (x >> 11);
        w = w ^ ((w << 7) & TEMPER_B);
        w = w ^ ((w << 15) & TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mtg_datapath.sv @@
// Datapath of the MT19937 generator: state memory, seed register, position
// and run counters, twist and temper logic, output register. Uses mtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtg_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [mtg_pkg::WORD_W-1:0]   cfg_wdata,
    input  wire logic [mtg_pkg::COUNT_W-1:0]  words_wanted,
    input  wire mtg_pkg::mtg_cmd_t            cmd,
    output mtg_pkg::mtg_stat_t                stat,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output logic [mtg_pkg::WORD_W-1:0]        m_tdata,
    output logic                              m_tlast
);

    // Twister state: one write port, two registered read ports.
    logic [mtg_pkg::WORD_W-1:0] mem [mtg_pkg::STATE_WORDS];

    logic [mtg_pkg::WORD_W-1:0]  seed_reg;
    logic                        needs_seed_reg;
    logic [mtg_pkg::ADDR_W-1:0]  seed_idx_reg;
    logic [mtg_pkg::WORD_W-1:0]  prev_reg;
    logic [mtg_pkg::ADDR_W-1:0]  pos_reg;
    logic [mtg_pkg::COUNT_W-1:0] remain_reg;
    logic [mtg_pkg::WORD_W-1:0]  cur_reg;
    logic [mtg_pkg::WORD_W-1:0]  rd_nxt_reg;
    logic [mtg_pkg::WORD_W-1:0]  rd_mid_reg;
    logic                        out_valid_reg;
    logic [mtg_pkg::WORD_W-1:0]  out_data_reg;
    logic                        out_last_reg;

    logic [mtg_pkg::ADDR_W-1:0]  nxt_addr;
    logic [mtg_pkg::ADDR_W-1:0]  mid_addr;
    logic [mtg_pkg::ADDR_W:0]    mid_sum;
    logic [mtg_pkg::COUNT_W-1:0] run_len;
    logic [mtg_pkg::WORD_W-1:0]  seed_word;
    logic [mtg_pkg::WORD_W-1:0]  new_word;
    logic                        mem_we;
    logic [mtg_pkg::ADDR_W-1:0]  mem_waddr;
    logic [mtg_pkg::WORD_W-1:0]  mem_wdata;

    // Neighbor addresses of the current position, wrapped at the state size.
    always_comb begin
        nxt_addr = (pos_reg == mtg_pkg::LAST_ADDR) ? '0 : pos_reg + 1'b1;
        mid_sum  = {1'b0, pos_reg} + (mtg_pkg::ADDR_W + 1)'(mtg_pkg::MIDDLE_OFFSET);
        if (mid_sum >= (mtg_pkg::ADDR_W + 1)'(mtg_pkg::STATE_WORDS)) begin
            mid_sum = mid_sum - (mtg_pkg::ADDR_W + 1)'(mtg_pkg::STATE_WORDS);
        end
        mid_addr = mid_sum[mtg_pkg::ADDR_W-1:0];
    end

    // Requests longer than a burst are cut to a burst.
    assign run_len = (words_wanted > mtg_pkg::BURST_MAX) ? mtg_pkg::BURST_MAX : words_wanted;

    // Seeding entry and twisted entry.
    assign seed_word = (seed_idx_reg == '0) ? seed_reg
                                            : mtg_pkg::seed_next(prev_reg, seed_idx_reg);
    assign new_word  = mtg_pkg::twist_word(cur_reg, rd_nxt_reg, rd_mid_reg);

    assign mem_we    = cmd.seed_step | cmd.twist;
    assign mem_waddr = cmd.twist ? pos_reg : seed_idx_reg;
    assign mem_wdata = cmd.twist ? new_word : seed_word;

    // State memory write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // State memory read ports.
    always_ff @(posedge aclk) begin
        if (cmd.read_issue) begin
            rd_nxt_reg <= mem[nxt_addr];
            rd_mid_reg <= mem[mid_addr];
        end
    end

    // Seed register and the reseed flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= mtg_pkg::DEFAULT_SEED;
            needs_seed_reg <= 1'b1;
        end else if (cfg_we) begin
            seed_reg       <= cfg_wdata;
            needs_seed_reg <= 1'b1;
        end else if (cmd.seed_step && seed_idx_reg == mtg_pkg::LAST_ADDR) begin
            needs_seed_reg <= 1'b0;
        end
    end

    // Seeding index, run length and state position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_idx_reg <= '0;
            remain_reg   <= '0;
            pos_reg      <= '0;
        end else begin
            if (cmd.run_load) begin
                seed_idx_reg <= '0;
                remain_reg   <= run_len;
            end else if (cmd.seed_step) begin
                seed_idx_reg <= seed_idx_reg + 1'b1;
            end
            if (cmd.seed_step && seed_idx_reg == mtg_pkg::LAST_ADDR) begin
                pos_reg <= '0;
            end else if (cmd.twist) begin
                pos_reg    <= nxt_addr;
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    // Previous seeding entry and a copy of the entry at the current position.
    always_ff @(posedge aclk) begin
        if (cmd.seed_step) begin
            prev_reg <= seed_word;
            if (seed_idx_reg == '0) begin
                cur_reg <= seed_word;
            end
        end else if (cmd.twist) begin
            cur_reg <= rd_nxt_reg;
        end
    end

    // Output register; a word waits here until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.twist) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.twist) begin
            out_data_reg <= mtg_pkg::temper(new_word);
            out_last_reg <= (remain_reg == mtg_pkg::COUNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Status toward the controller.
    always_comb begin
        stat.req_zero   = (words_wanted == '0);
        stat.needs_seed = needs_seed_reg;
        stat.seed_last  = (seed_idx_reg == mtg_pkg::LAST_ADDR);
        stat.run_last   = (remain_reg == mtg_pkg::COUNT_W'(1));
        stat.out_free   = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

@@ rtl/mtg_ctrl.sv @@
// Controller of the MT19937 generator: sequences seeding, memory reads and
// twists for one request at a time. Uses mtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire mtg_pkg::mtg_stat_t stat,
    output mtg_pkg::mtg_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SEED  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_TWIST = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.run_load = 1'b1;
                    if (!stat.req_zero) begin
                        state_next = stat.needs_seed ? ST_SEED : ST_READ;
                    end
                end
            end
            ST_SEED: begin
                cmd.seed_step = 1'b1;
                if (stat.seed_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_issue = 1'b1;
                state_next     = ST_TWIST;
            end
            ST_TWIST: begin
                if (stat.out_free) begin
                    cmd.twist  = 1'b1;
                    state_next = stat.run_last ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/mersenne_twister_generator.sv @@
// MT19937 generator: a request of 1 to 64 words yields that many tempered words.
// The first word follows a read state and a twist state after the request; the first
// request after reset or after a seed write runs a seeding pass over the whole state first.
// Each word takes a read on the two memory read ports, then a twist, which waits while
// the output register holds a word the consumer does not take; words do not overlap.
// Reset sets the seed to 5489 and forces a reseed; the state memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,     // seed_value
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [6:0] words_wanted, [7] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [31:0] random_word
    output logic             m_tlast        // last_of_run
);

    mtg_pkg::mtg_cmd_t  cmd;
    mtg_pkg::mtg_stat_t stat;

    mtg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtg_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .words_wanted (s_tdata[mtg_pkg::COUNT_W-1:0]),
        .cmd          (cmd),
        .stat         (stat),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/mtg_checker.sv @@
// Port-level checker for the MT19937 generator, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtg_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled word stays offered.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // A stalled word keeps its value.
    `ASSERT_CLK(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))

    // Once a nonempty request is taken, no other request is taken next cycle.
    `ASSERT_CLK(a_one_run, aclk, aresetn, s_tvalid && s_tready && s_tdata[6:0] != 7'd0 |=> !s_tready)

    // Reset leaves the block ready with no word pending.
    `ASSERT_ALL(a_reset_idle, aclk, !aresetn |=> s_tready && !m_tvalid)

endmodule

bind mersenne_twister_generator mtg_port_checker u_mtg_checker (.*);

`default_nettype wire

@@ dv/mtg_checker.sv @@
// Checker for the MT19937 generator: watches the seed port and both stream channels,
// predicts every tempered word and compares it with what the block delivers.
// Depends on mtg_pkg for the state size and the generator constants.
`timescale 1ns / 1ps

module mtg_checker
    import mtg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tlast,
    output int               error_count,
    output int               words_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } mt_word_t;

    // Shadow copy of the generator state and its seed register.
    logic [31:0] mt_state [STATE_WORDS];
    int unsigned mt_index;
    bit          seed_due;
    logic [31:0] seed_reg;

    mt_word_t expected_words[$];
    mt_word_t head_word;
    int       errors;

    // Fill the whole state from the seed with the multiplicative recurrence.
    function automatic void seed_state();
        mt_state[0] = seed_reg;
        for (int i = 1; i < STATE_WORDS; i++) begin
            mt_state[i] = SEED_MULT * (mt_state[i-1] ^ (mt_state[i-1] >> 30)) + 32'(i);
        end
        mt_index = 0;
        seed_due = 1'b0;
    endfunction

    // Twist the current entry in place and return its tempered value.
    function automatic logic [31:0] draw_word();
        int unsigned cur;
        int unsigned nxt;
        int unsigned mid;
        logic [31:0] mixed;
        logic [31:0] w;
        cur   = (mt_index >= STATE_WORDS) ? 0 : mt_index;
        nxt   = (cur + 1) % STATE_WORDS;
        mid   = (cur + MIDDLE_OFFSET) % STATE_WORDS;
        mixed = {mt_state[cur][31], mt_state[nxt][30:0]};
        w     = mt_state[mid] ^ (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : 32'h0);
        mt_state[cur] = w;
        mt_index      = nxt;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & TEMPER_B);
        w = w ^ ((w << 15) & TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

    // A request of zero words changes nothing; those longer than a burst are clipped to a full burst.
    function automatic void predict_run(input logic [6:0] wanted);
        int unsigned count;
        mt_word_t    item;
        count = (wanted > MAX_BURST) ? MAX_BURST : wanted;
        if (count != 0) begin
            if (seed_due) begin
                seed_state();
            end
            for (int k = 0; k < count; k++) begin
                item.word = draw_word();
                item.last = (k + 1 == count);
                expected_words.push_back(item);
            end
        end
    endfunction

    // Results are checked before new requests so that a stray word is never
    // matched against the words of a request accepted in the same cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg = DEFAULT_SEED;
            mt_index = STATE_WORDS;
            seed_due = 1'b1;
            errors   = 0;
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: unexpected word %h last %b, none expected",
                                 $realtime, m_tdata, m_tlast);
                    end
                    errors++;
                end else begin
                    head_word = expected_words.pop_front();
                    if (m_tdata !== head_word.word || m_tlast !== head_word.last) begin
                        if (errors < 10) begin
                            $display("%0t: word mismatch, expected %h last %b, got %h last %b",
                                     $realtime, head_word.word, head_word.last, m_tdata, m_tlast);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_we) begin
                seed_reg = cfg_wdata;
                seed_due = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                predict_run(s_tdata[6:0]);
            end
        end
        error_count   <= errors;
        words_pending <= expected_words.size();
    end

endmodule

@@ dv/tb_mersenne_twister_generator.sv @@
// Testbench top for the MT19937 generator: drives seed writes and word requests,
// stalls the result channel at random and reports the verdict.
// Depends on mtg_pkg, the generator RTL and the checker in mtg_checker.sv.
`timescale 1ns / 1ps

module tb_mersenne_twister_generator;
    import mtg_pkg::*;

    // The longest quiet stretch of a correct run is a seeding pass plus short
    // stalls and the settle wait, so this limit is ample.
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 30;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire         m_tlast;

    int error_count;
    int words_pending;
    bit idle_enable  = 1'b1;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    mersenne_twister_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mtg_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    // The receiver drops tready in bursts of random length when idle_enable is set.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no transaction of any kind happens.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with an occasional gap ahead of it, and wait for its transaction.
    task automatic send_request(input logic [6:0] wanted);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, wanted};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every predicted word has arrived and the block settles.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly short and full-range runs, with a few empty and oversized requests.
    function automatic logic [6:0] random_count();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 7'd0;
        if (pick == 1) return 7'($urandom_range(MAX_BURST + 1, 127));
        if (pick < 8) return 7'($urandom_range(1, 8));
        return 7'($urandom_range(1, MAX_BURST));
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: an empty request before any seeding, then the default seed.
        send_request(7'd0);
        send_request(7'd1);
        send_request(7'd64);
        send_request(7'd127);
        send_request(7'd65);
        send_request(7'd0);
        send_request(7'd2);
        // Reseeding after words have been drawn, with both extreme seeds.
        write_seed(32'h0000_0000);
        send_request(7'd5);
        send_request(7'd63);
        write_seed(32'hffff_ffff);
        send_request(7'd0);
        send_request(7'd3);
        send_request(7'd64);
        write_seed(DEFAULT_SEED);
        send_request(7'd42);
        send_request(7'd21);
        send_request(7'd10);

        // Random phases; the first keeps the default seed long enough to wrap the state.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_enable = (phase != 2) && (phase != RANDOM_PHASES - 1);
            if (phase > 0) begin
                write_seed($urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_request(random_count());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && words_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mtg_pkg.sv
rtl/mtg_datapath.sv
rtl/mtg_ctrl.sv
rtl/mersenne_twister_generator.sv
rtl/mtg_checker.sv
dv/mtg_checker.sv
dv/tb_mersenne_twister_generator.sv
